@@ hdl/bwgs_pkg.sv @@
// Package for the bootloader write/go sequencer: operation and status codes,
// protocol bytes and the job record passed from the front end to the back end.
// Depends on nothing; every module and the testbench import it.
`default_nettype none

package bwgs_pkg;

  // Field widths
  localparam int LenW  = 9;
  localparam int AddrW = 32;

  // Operation codes of an input request
  localparam logic [1:0] OP_START_WRITE = 2'd0;
  localparam logic [1:0] OP_START_GO    = 2'd1;
  localparam logic [1:0] OP_PAYLOAD     = 2'd2;
  localparam logic [1:0] OP_REPLY       = 2'd3;

  // Status codes of a report
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_NACK  = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_PLACE = 3'd4;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Protocol bytes
  localparam logic [7:0] ACK_BYTE      = 8'h79;
  localparam logic [7:0] NACK_BYTE     = 8'h1f;
  localparam logic [7:0] CMD_WRITE     = 8'h31;
  localparam logic [7:0] CMD_WRITE_INV = 8'hce;
  localparam logic [7:0] CMD_GO        = 8'h21;
  localparam logic [7:0] CMD_GO_INV    = 8'hde;

  // Queue between front and back
  localparam int JobBytes = 5;
  localparam int JobIdxW  = $clog2(JobBytes);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // One job: either a single status report or one to five bytes to transmit
  typedef struct packed {
    logic                      is_status;
    logic [2:0]                status;
    logic [JobIdxW-1:0]        count_m1;
    logic [JobBytes-1:0][7:0]  data;
  } job_t;

endpackage

`default_nettype wire

@@ hdl/bwgs_in_if.sv @@
// Input channel of the sequencer: valid/ready handshake with one request.
// Depends on nothing.
`default_nettype none

interface bwgs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] target_address;
  logic [8:0]  block_length;
  logic [7:0]  payload_byte;
  logic [7:0]  reply_byte;

  modport source (output valid, operation, target_address, block_length,
                  payload_byte, reply_byte, input ready);
  modport sink   (input valid, operation, target_address, block_length,
                  payload_byte, reply_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/bwgs_out_if.sv @@
// Output channel of the sequencer: valid/ready handshake with one result.
// Depends on nothing.
`default_nettype none

interface bwgs_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, kind, tx_byte, status, last, input ready);
  modport sink   (input valid, kind, tx_byte, status, last, output ready);
endinterface

`default_nettype wire

@@ hdl/bootloader_write_go_sequencer.sv @@
// Host-side sequencer for the serial bootloader Write Memory and Go commands.
// Channels: in_ch takes requests (start write, start go, payload byte, reply
// byte from target); out_ch gives results (a byte to transmit or a status
// report), with last marking the final result of each request.
// A request's job is written into the job queue; its results are offered once it reaches the queue head.
// Throughput: one request a cycle while the four-entry job queue has room;
// out_ch moves one result a cycle while its ready is high; a request has one
// to five results (the address phase is the longest).
// A stalled out_ch holds the current result steady; in_ch keeps accepting
// until the job queue fills, then drops ready.
// Reset (synchronous, active high) returns the phase machine to idle, clears
// the sticky error flag and empties the queue; no clearing pass is needed.
// Depends on bwgs_pkg, bwgs_in_if, bwgs_out_if, bwgs_front, bwgs_queue,
// bwgs_back.
`default_nettype none

module bootloader_write_go_sequencer #(
  parameter int MAX_BLOCK = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bwgs_in_if.sink    in_ch,
  bwgs_out_if.source out_ch
);
  import bwgs_pkg::*;

  job_t front_job;
  job_t head;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  bwgs_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .job   (front_job),
    .push  (push),
    .full  (full)
  );

  bwgs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  bwgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ hdl/bwgs_front.sv @@
// Front end: accepts requests, runs the command phase machine and turns each
// request into one job for the queue. Depends on bwgs_pkg and bwgs_in_if.
`default_nettype none

module bwgs_front #(
  parameter int MAX_BLOCK = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  bwgs_in_if.sink            in_ch,
  output bwgs_pkg::job_t     job,
  output logic               push,
  input  wire logic          full
);
  import bwgs_pkg::*;

  localparam int CntW = $clog2(MAX_BLOCK + 1);

  // Phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CMD_ACK  = 3'd1;
  localparam logic [2:0] PH_ADDR_ACK = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_DATA_ACK = 3'd4;

  logic [2:0]       phase, phase_next;
  logic             is_write, is_write_next;
  logic [AddrW-1:0] saved_address, saved_address_next;
  logic [CntW-1:0]  bytes_left, bytes_left_next;
  logic [7:0]       running_checksum, running_checksum_next;
  logic             error_latched, error_latched_next;

  logic             accept;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_m1;
  logic [LenW-1:0]  left_m1;
  logic [CntW-1:0]  left_dec;
  logic [7:0]       csum_pay;
  logic             bad_len;
  logic             waiting;
  logic [7:0]       a3, a2, a1, a0;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;
  assign push        = accept;

  assign len      = in_ch.block_length;
  assign len_m1   = len - LenW'(1);
  assign left_m1  = LenW'(bytes_left) - LenW'(1);
  assign left_dec = bytes_left - CntW'(1);
  assign csum_pay = running_checksum ^ in_ch.payload_byte;
  assign bad_len  = (len == '0) || (len > LenW'(MAX_BLOCK));
  assign waiting  = (phase == PH_CMD_ACK) || (phase == PH_ADDR_ACK) ||
                    (phase == PH_DATA_ACK);
  assign a3 = saved_address[31:24];
  assign a2 = saved_address[23:16];
  assign a1 = saved_address[15:8];
  assign a0 = saved_address[7:0];

  // Decode the request into a job and the next phase
  always_comb begin
    phase_next            = phase;
    is_write_next         = is_write;
    saved_address_next    = saved_address;
    bytes_left_next       = bytes_left;
    running_checksum_next = running_checksum;
    error_latched_next    = error_latched;
    job.is_status         = 1'b1;
    job.status            = ST_PLACE;
    job.count_m1          = '0;
    job.data              = '0;
    unique case (in_ch.operation)
      OP_START_WRITE, OP_START_GO: begin
        if (phase == PH_IDLE &&
            !(in_ch.operation == OP_START_WRITE && bad_len)) begin
          is_write_next      = (in_ch.operation == OP_START_WRITE);
          saved_address_next = in_ch.target_address;
          phase_next         = PH_CMD_ACK;
          job.is_status      = 1'b0;
          job.status         = ST_NONE;
          job.count_m1       = JobIdxW'(1);
          if (in_ch.operation == OP_START_WRITE) begin
            bytes_left_next       = CntW'(len);
            running_checksum_next = len_m1[7:0];
            job.data[0]           = CMD_WRITE;
            job.data[1]           = CMD_WRITE_INV;
          end else begin
            bytes_left_next       = '0;
            running_checksum_next = '0;
            job.data[0]           = CMD_GO;
            job.data[1]           = CMD_GO_INV;
          end
        end
      end
      OP_PAYLOAD: begin
        if (phase == PH_PAYLOAD) begin
          running_checksum_next = csum_pay;
          bytes_left_next       = left_dec;
          job.is_status         = 1'b0;
          job.status            = ST_NONE;
          job.data[0]           = in_ch.payload_byte;
          // Append the checksum after the final payload byte
          if (left_dec == '0) begin
            job.count_m1 = JobIdxW'(1);
            job.data[1]  = csum_pay;
            phase_next   = PH_DATA_ACK;
          end
        end
      end
      OP_REPLY: begin
        if (waiting) begin
          if (in_ch.reply_byte != ACK_BYTE) begin
            job.status         = (in_ch.reply_byte == NACK_BYTE) ? ST_NACK : ST_BAD;
            error_latched_next = 1'b1;
            phase_next         = PH_IDLE;
          end else if (phase == PH_CMD_ACK) begin
            job.is_status = 1'b0;
            job.status    = ST_NONE;
            job.count_m1  = JobIdxW'(JobBytes - 1);
            job.data[0]   = a3;
            job.data[1]   = a2;
            job.data[2]   = a1;
            job.data[3]   = a0;
            job.data[4]   = a3 ^ a2 ^ a1 ^ a0;
            phase_next    = PH_ADDR_ACK;
          end else if (phase == PH_ADDR_ACK && is_write) begin
            job.is_status = 1'b0;
            job.status    = ST_NONE;
            job.data[0]   = left_m1[7:0];
            phase_next    = PH_PAYLOAD;
          end else begin
            job.status = ST_DONE;
            phase_next = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      is_write         <= 1'b0;
      saved_address    <= '0;
      bytes_left       <= '0;
      running_checksum <= '0;
      error_latched    <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      is_write         <= is_write_next;
      saved_address    <= saved_address_next;
      bytes_left       <= bytes_left_next;
      running_checksum <= running_checksum_next;
      error_latched    <= error_latched_next;
    end
  end

  // Error flag is sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(error_latched) && !$past(rst) |-> error_latched)
    else $error("error flag dropped without reset");

  // Payload phase always has bytes left to count
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with zero bytes left");

endmodule

`default_nettype wire

@@ hdl/bwgs_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on bwgs_pkg.
`default_nettype none

module bwgs_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bwgs_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output bwgs_pkg::job_t       head,
  output logic                 head_valid
);
  import bwgs_pkg::*;

  job_t              slots [QDepth];
  logic [QPtrW-1:0]  wptr;
  logic [QPtrW-1:0]  rptr;
  logic [QCntW-1:0]  cnt;

  assign full       = (cnt == QCntW'(QDepth));
  assign head_valid = (cnt != '0);
  assign head       = slots[rptr];

  // Store a job at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPtrW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + QCntW'(1);
        2'b01:   cnt <= cnt - QCntW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

@@ hdl/bwgs_back.sv @@
// Back end: walks the job at the queue head and emits its results one a cycle while out_ch is ready.
// Depends on bwgs_pkg and bwgs_out_if.
`default_nettype none

module bwgs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bwgs_pkg::job_t  head,
  input  wire logic            head_valid,
  output logic                 pop,
  bwgs_out_if.source           out_ch
);
  import bwgs_pkg::*;

  logic [JobIdxW-1:0] idx;
  logic               at_last;
  logic               fire;

  assign at_last = (idx == head.count_m1);
  assign fire    = head_valid && out_ch.ready;
  assign pop     = fire && at_last;

  assign out_ch.valid   = head_valid;
  assign out_ch.kind    = head.is_status ? KIND_STATUS : KIND_BYTE;
  assign out_ch.tx_byte = head.is_status ? 8'h00 : head.data[idx];
  assign out_ch.status  = head.status;
  assign out_ch.last    = at_last;

  // Step through the bytes of the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= at_last ? '0 : idx + JobIdxW'(1);
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for bootloader_write_go_sequencer: directed and random requests
// on in_ch, each result on out_ch checked against a built-in predictor.
// Depends on bwgs_pkg, bwgs_in_if, bwgs_out_if and the sequencer RTL.

import bwgs_pkg::*;

typedef enum logic [2:0] {
  PH_IDLE,
  PH_CMD_ACK,
  PH_ADDR_ACK,
  PH_PAYLOAD,
  PH_DATA_ACK
} seq_phase_t;

typedef struct packed {
  logic       kind;
  logic [7:0] tx_byte;
  logic [2:0] status;
  logic       last;
} seq_result_t;

// Predict the sequencer's output stream and check it in order
class seq_scoreboard;
  seq_phase_t  phase;
  logic        is_write;
  logic [31:0] saved_addr;
  logic [8:0]  bytes_left;
  logic [7:0]  checksum;
  logic        error_seen;
  int          max_block;
  int          mismatches;
  seq_result_t pending_results[$];
  seq_result_t step_results[$];

  function new(int max_block_len);
    max_block  = max_block_len;
    phase      = PH_IDLE;
    is_write   = 1'b0;
    saved_addr = '0;
    bytes_left = '0;
    checksum   = '0;
    error_seen = 1'b0;
    mismatches = 0;
  endfunction

  function void push_byte(logic [7:0] b);
    seq_result_t r;
    r = '{KIND_BYTE, b, ST_NONE, 1'b0};
    step_results = {step_results, r};
  endfunction

  function void push_status(logic [2:0] s);
    seq_result_t r;
    r = '{KIND_STATUS, 8'h00, s, 1'b0};
    step_results = {step_results, r};
  endfunction

  // Advance the predicted state by one accepted request, queue its results
  function void note_request(logic [1:0] op, logic [31:0] addr, logic [8:0] len,
                             logic [7:0] pay, logic [7:0] rep);
    logic [8:0]  len_m1;
    logic [7:0]  a3, a2, a1, a0;
    seq_result_t r;
    step_results.delete();
    case (op)
      OP_START_WRITE, OP_START_GO: begin
        if (phase != PH_IDLE ||
            (op == OP_START_WRITE && (len == 0 || len > max_block))) begin
          push_status(ST_PLACE);
        end else begin
          is_write   = (op == OP_START_WRITE);
          saved_addr = addr;
          len_m1     = len - 9'd1;
          bytes_left = is_write ? len : 9'd0;
          checksum   = is_write ? len_m1[7:0] : 8'h00;
          push_byte(is_write ? CMD_WRITE : CMD_GO);
          push_byte(is_write ? CMD_WRITE_INV : CMD_GO_INV);
          phase = PH_CMD_ACK;
        end
      end
      OP_PAYLOAD: begin
        if (phase != PH_PAYLOAD) begin
          push_status(ST_PLACE);
        end else begin
          push_byte(pay);
          checksum   = checksum ^ pay;
          bytes_left = bytes_left - 9'd1;
          if (bytes_left == 0) begin
            push_byte(checksum);
            phase = PH_DATA_ACK;
          end
        end
      end
      default: begin
        if (phase != PH_CMD_ACK && phase != PH_ADDR_ACK && phase != PH_DATA_ACK) begin
          push_status(ST_PLACE);
        end else if (rep != ACK_BYTE) begin
          // Abort the command and latch the error
          push_status(rep == NACK_BYTE ? ST_NACK : ST_BAD);
          error_seen = 1'b1;
          phase      = PH_IDLE;
        end else if (phase == PH_CMD_ACK) begin
          a3 = saved_addr[31:24];
          a2 = saved_addr[23:16];
          a1 = saved_addr[15:8];
          a0 = saved_addr[7:0];
          push_byte(a3);
          push_byte(a2);
          push_byte(a1);
          push_byte(a0);
          push_byte(a3 ^ a2 ^ a1 ^ a0);
          phase = PH_ADDR_ACK;
        end else if (phase == PH_ADDR_ACK && is_write) begin
          len_m1 = bytes_left - 9'd1;
          push_byte(len_m1[7:0]);
          phase = PH_PAYLOAD;
        end else begin
          push_status(ST_DONE);
          phase = PH_IDLE;
        end
      end
    endcase
    // Mark the final result of this request
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      if (i == step_results.size() - 1) r.last = 1'b1;
      pending_results = {pending_results, r};
    end
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest expectation
  task check_result(logic kind, logic [7:0] tx_byte, logic [2:0] status, logic last);
    seq_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result kind=%0d tx=%02h status=%0d last=%0d",
                       kind, tx_byte, status, last));
      return;
    end
    want = pending_results.pop_front();
    if (kind !== want.kind)
      report($sformatf("kind %0d, want %0d", kind, want.kind));
    if (tx_byte !== want.tx_byte)
      report($sformatf("tx_byte %02h, want %02h", tx_byte, want.tx_byte));
    if (status !== want.status)
      report($sformatf("status %0d, want %0d", status, want.status));
    if (last !== want.last)
      report($sformatf("last %0d, want %0d", last, want.last));
  endtask
endclass

module tb_top;
  localparam int MaxBlock    = 256;
  localparam int ItemTarget  = 200;
  localparam int MaxStartAt  = 140;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 20;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   in_quiet    = 0;
  int   out_quiet   = 0;
  int   rand_count  = 0;
  int   rand_target = ItemTarget;
  bit   max_done    = 1'b0;

  seq_scoreboard sb;

  bwgs_in_if  in_ch ();
  bwgs_out_if out_ch ();

  bootloader_write_go_sequencer #(
    .MAX_BLOCK(MaxBlock)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Draw an idle count; now and then hold a stretch with no idling
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [8:0] len,
                              logic [7:0] pay, logic [7:0] rep);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.target_address <= addr;
    in_ch.block_length   <= len;
    in_ch.payload_byte   <= pay;
    in_ch.reply_byte     <= rep;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, addr, len, pay, rep);
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Pick the next request: mostly the well-formed next step, some noise
  task automatic send_random_request();
    logic [1:0]  op;
    logic [31:0] addr;
    logic [8:0]  len;
    logic [7:0]  pay;
    logic [7:0]  rep;
    int          r;
    addr = $urandom;
    len  = 9'($urandom_range(0, 511));
    pay  = 8'($urandom_range(0, 255));
    rep  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 12) begin
      op = 2'($urandom_range(0, 3));
      // Keep noise starts short or out of range
      if (op == OP_START_WRITE)
        len = $urandom_range(0, 1) ? 9'($urandom_range(257, 511))
                                   : 9'($urandom_range(0, 4));
    end else begin
      case (sb.phase)
        PH_IDLE: begin
          op = ($urandom_range(0, 9) < 6) ? OP_START_WRITE : OP_START_GO;
          // Late in the run, open one full-size write that runs to the end
          if (!max_done && rand_count >= MaxStartAt) begin
            max_done = 1'b1;
            op       = OP_START_WRITE;
            len      = 9'(MaxBlock);
          end else if ($urandom_range(0, 99) < 85) begin
            len = 9'($urandom_range(1, 6));
          end else begin
            len = 9'($urandom_range(7, 24));
          end
        end
        PH_PAYLOAD: op = OP_PAYLOAD;
        default: begin
          op = OP_REPLY;
          r  = $urandom_range(0, 99);
          if (r < 88) rep = ACK_BYTE;
          else if (r < 94) rep = NACK_BYTE;
        end
      endcase
    end
    send_request(op, addr, len, pay, rep);
  endtask

  // Accept results with random stalls and check each one
  task automatic accept_results();
    int stall;
    forever begin
      stall = draw_wait(out_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.kind, out_ch.tx_byte, out_ch.status, out_ch.last);
    end
  endtask

  initial begin
    sb = new(MaxBlock);
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_START_WRITE;
    in_ch.target_address <= '0;
    in_ch.block_length   <= '0;
    in_ch.payload_byte   <= '0;
    in_ch.reply_byte     <= '0;
    out_ch.ready         <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    fork
      accept_results();
    join_none

    // Misplaced requests and bad lengths while idle
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_PAYLOAD, 32'h0, 9'd0, 8'h5a, 8'h00);
    send_request(OP_START_WRITE, $urandom, 9'd0, 8'h00, 8'h00);
    send_request(OP_START_WRITE, $urandom, 9'd257, 8'h00, 8'h00);
    send_request(OP_START_WRITE, $urandom, 9'd511, 8'hff, 8'hff);

    // Full go at the top address
    send_request(OP_START_GO, 32'hffff_ffff, 9'h1ff, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);

    // Shortest write with requests out of place in the command-ack, payload and data-ack phases
    send_request(OP_START_WRITE, 32'h0, 9'd1, 8'h00, 8'h00);
    send_request(OP_START_GO, $urandom, 9'd0, 8'h00, 8'h00);
    send_request(OP_PAYLOAD, 32'h0, 9'd0, 8'h11, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_PAYLOAD, 32'h0, 9'd0, 8'hff, 8'h00);
    send_request(OP_START_WRITE, $urandom, 9'd1, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);

    // Aborts: nack on command, bad reply on command, nack on address,
    // bad reply on the data acknowledge
    send_request(OP_START_WRITE, 32'h1234_5678, 9'd2, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, NACK_BYTE);
    send_request(OP_START_GO, $urandom, 9'd0, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, 8'h00);
    send_request(OP_START_GO, $urandom, 9'd0, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, NACK_BYTE);
    send_request(OP_START_WRITE, $urandom, 9'd1, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, ACK_BYTE);
    send_request(OP_PAYLOAD, 32'h0, 9'd0, 8'h00, 8'h00);
    send_request(OP_REPLY, 32'h0, 9'd0, 8'h00, 8'hff);
    wait_for_results();

    // Random requests, with an occasional full drain
    while (rand_count < rand_target) begin
      send_random_request();
      rand_count++;
      if ($urandom_range(0, 49) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
